// ===== hw/rtl/fhra_pkg.sv =====
// Types and codes shared by the handle allocator.
// Depends on nothing; imported by the allocator top, handle_pool_checker and tb_top.
package fhra_pkg;

   // Request codes
   localparam logic [1:0] REQ_ALLOC = 2'd0;
   localparam logic [1:0] REQ_TRY   = 2'd1;
   localparam logic [1:0] REQ_FREE  = 2'd2;

   // Response status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_FREED  = 2'd1,
      ST_NOT_ALLOC = 2'd2,
      ST_EXHAUSTED = 2'd3
   } status_type;

   // Sequencer states
   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   // Request item
   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] release_handle;
   } req_item_type;

   // Response item
   typedef struct packed {
      logic [7:0] granted_handle;
      status_type status;
   } rsp_item_type;

endpackage

// ===== hw/rtl/fifo_recycling_handle_allocator_top.sv =====
// Handle allocator with FIFO recycling of freed handles.
// Depends on fhra_pkg for the item types, request codes and status codes.
//
//   channel   handshake                   payload
//   request   start / busy                req_item  (req_type, release_handle)
//   response  rsp_strobe (one cycle)      rsp_item  (granted_handle, status)
//
// An item is handled in two steps: the accept edge reads the mark memory and the
// free-queue memory, the next edge decides and writes both back. busy is
// high in the execute state between them, so no item is accepted meanwhile.
// The response is loaded at the write-back edge and shows for the cycle after
// it, at whose closing edge the next item may already be accepted.
// The receiver cannot stall; no buffering is held.
// Reset is synchronous and takes effect at once: marks at or above the fresh
// counter read as clear, so no clearing pass is needed.
module fifo_recycling_handle_allocator_top #(
   parameter int NUM_HANDLES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  fhra_pkg::req_item_type req_item,
   output logic                  rsp_strobe,
   output fhra_pkg::rsp_item_type rsp_item
);
   import fhra_pkg::*;

   localparam int IW = $clog2(NUM_HANDLES);
   localparam int CW = (IW + 1 > 9) ? IW + 1 : 9;
   localparam logic [IW:0]   NUM_W  = (IW + 1)'(NUM_HANDLES);
   localparam logic [IW-1:0] LAST_W = IW'(NUM_HANDLES - 1);

   // Memories
   logic             mark_mem  [NUM_HANDLES];
   logic [7:0]       queue_mem [NUM_HANDLES];

   // Control and payload registers
   state_type        state_ff, state_in;
   logic [IW-1:0]    head_ff, head_in;
   logic [IW-1:0]    tail_ff, tail_in;
   logic [IW:0]      count_ff, count_in;
   logic [IW:0]      fresh_ff, fresh_in;
   req_item_type     req_ff;
   logic             mark_rd_ff;
   logic [7:0]       queue_rd_ff;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_item_type     rsp_ff, rsp_in;

   // Write-back controls
   logic             accept;
   logic             exec;
   logic             mark_we;
   logic [IW-1:0]    mark_wa;
   logic             mark_wd;
   logic             queue_we;

   // Widened views for compares and address slicing
   logic [CW-1:0]    rd_rel_wide;
   logic [CW-1:0]    rel_wide;
   logic [CW-1:0]    fresh_wide;
   logic [CW-1:0]    pop_wide;
   logic             queue_nonempty;
   logic             fresh_left;
   logic             mark_set;

   assign accept      = start && (state_ff == S_IDLE);
   assign exec        = (state_ff == S_EXEC);
   assign rd_rel_wide = CW'(req_item.release_handle);
   assign rel_wide    = CW'(req_ff.release_handle);
   assign fresh_wide  = CW'(fresh_ff);
   assign pop_wide    = CW'(queue_rd_ff);

   assign queue_nonempty = (count_ff != '0);
   assign fresh_left     = (fresh_ff != NUM_W);
   // Entries at or above the fresh counter were never issued and read as clear
   assign mark_set       = (rel_wide < fresh_wide) && mark_rd_ff;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state: each accept is followed by the execute state, then idle
   always_comb begin
      state_in = state_ff;
      busy     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            busy     = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Decide the item and build the write-back
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      fresh_in      = fresh_ff;
      mark_we       = 1'b0;
      mark_wa       = fresh_ff[IW-1:0];
      mark_wd       = 1'b1;
      queue_we      = 1'b0;
      rsp_strobe_in = exec;
      rsp_in.granted_handle = 8'd0;
      rsp_in.status         = ST_OK;
      if (exec) begin
         case (req_ff.req_type)
            REQ_ALLOC, REQ_TRY: begin
               if (queue_nonempty) begin
                  // pop the oldest freed handle
                  mark_we  = 1'b1;
                  mark_wa  = pop_wide[IW-1:0];
                  head_in  = (head_ff == LAST_W) ? '0 : head_ff + 1'b1;
                  count_in = count_ff - 1'b1;
                  rsp_in.granted_handle = queue_rd_ff;
               end else if (req_ff.req_type == REQ_TRY) begin
                  rsp_in.status = ST_NO_FREED;
               end else if (fresh_left) begin
                  // issue a fresh handle
                  mark_we  = 1'b1;
                  mark_wa  = fresh_ff[IW-1:0];
                  fresh_in = fresh_ff + 1'b1;
                  rsp_in.granted_handle = fresh_wide[7:0];
               end else begin
                  rsp_in.status = ST_EXHAUSTED;
               end
            end
            REQ_FREE: begin
               if (mark_set) begin
                  // clear the mark and queue the handle for reuse
                  mark_we = 1'b1;
                  mark_wa = rel_wide[IW-1:0];
                  mark_wd = 1'b0;
                  if (count_ff != NUM_W) begin
                     queue_we = 1'b1;
                     tail_in  = (tail_ff == LAST_W) ? '0 : tail_ff + 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end else begin
                  rsp_in.status = ST_NOT_ALLOC;
               end
            end
            default: begin
               rsp_in.status = ST_OK;
            end
         endcase
      end
   end

   // Pointer, counter and strobe registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         fresh_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         fresh_ff      <= fresh_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Hold the request and the response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_item;
      end
      if (exec) begin
         rsp_ff <= rsp_in;
      end
   end

   // Mark memory: read at accept, write back in the execute cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         mark_rd_ff <= mark_mem[rd_rel_wide[IW-1:0]];
      end
      if (mark_we) begin
         mark_mem[mark_wa] <= mark_wd;
      end
   end

   // Free-queue memory: read the head at accept, push at the tail
   always_ff @(posedge clock) begin
      if (accept) begin
         queue_rd_ff <= queue_mem[head_ff];
      end
      if (queue_we) begin
         queue_mem[tail_ff] <= req_ff.release_handle;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

`ifndef SYNTHESIS
   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not enter execute");

   a_strobe_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == S_EXEC))
      else $error("response without an execute cycle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= NUM_W) && (count_ff <= fresh_ff))
      else $error("free-queue count exceeds issued handles");

   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= NUM_W)
      else $error("fresh counter beyond pool size");
`endif

endmodule

// ===== sim/handle_pool_checker.sv =====
// Checker for the handle allocator: predicts each response and compares it.
// Depends on fhra_pkg for the item types, request codes and status codes.
// Watches the start/busy request channel and the strobed response channel.
module handle_pool_checker #(
   parameter int NUM_HANDLES = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  fhra_pkg::req_item_type req_item,
   input  logic                   rsp_strobe,
   input  fhra_pkg::rsp_item_type rsp_item,
   output int                     mismatches,
   output int                     pending,
   output int                     n_checked,
   output int                     n_recycled,
   output int                     n_exhausted,
   output int                     n_refused
);
   timeunit 1ns;
   timeprecision 1ps;
   import fhra_pkg::*;

   // Predicted allocator state
   bit           handle_marks [NUM_HANDLES];
   logic [7:0]   freed_handles [$];
   int           fresh_next;

   // Responses still owed by the block, oldest first
   rsp_item_type expected_grants [$];
   rsp_item_type owed;
   rsp_item_type predicted;

   // Work out the response to one request and advance the predicted state
   task automatic grant_or_refuse(input req_item_type item, output rsp_item_type outcome);
      logic [7:0] h;
      outcome.granted_handle = '0;
      outcome.status         = ST_OK;
      case (item.req_type)
         REQ_ALLOC, REQ_TRY: begin
            if (freed_handles.size() != 0) begin
               // oldest freed handle goes out first
               h = freed_handles.pop_front();
               handle_marks[h] = 1'b1;
               outcome.granted_handle = h;
               n_recycled++;
            end else if (item.req_type == REQ_TRY) begin
               outcome.status = ST_NO_FREED;
               n_refused++;
            end else if (fresh_next < NUM_HANDLES) begin
               handle_marks[fresh_next] = 1'b1;
               outcome.granted_handle = 8'(fresh_next);
               fresh_next++;
            end else begin
               outcome.status = ST_EXHAUSTED;
               n_exhausted++;
            end
         end
         REQ_FREE: begin
            // only a handle currently out may come back
            if (item.release_handle < NUM_HANDLES && handle_marks[item.release_handle]) begin
               freed_handles.push_back(item.release_handle);
               handle_marks[item.release_handle] = 1'b0;
            end else begin
               outcome.status = ST_NOT_ALLOC;
               n_refused++;
            end
         end
         default: ;
      endcase
   endtask

   // Count a failure; describe only the first few
   task automatic note_mismatch(input string what, input int want, input int got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
   endtask

   // Compare responses first, since one leaving now belongs to an earlier item
   always @(posedge clock) begin
      if (reset) begin
         foreach (handle_marks[i]) handle_marks[i] = 1'b0;
         freed_handles.delete();
         expected_grants.delete();
         fresh_next  = 0;
         mismatches  = 0;
         n_checked   = 0;
         n_recycled  = 0;
         n_exhausted = 0;
         n_refused   = 0;
         pending    <= 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_grants.size() == 0) begin
               note_mismatch("unexpected response, granted_handle", -1,
                             int'(rsp_item.granted_handle));
            end else begin
               owed = expected_grants.pop_front();
               n_checked++;
               if (rsp_item.granted_handle !== owed.granted_handle)
                  note_mismatch("granted_handle", int'(owed.granted_handle),
                                int'(rsp_item.granted_handle));
               if (rsp_item.status !== owed.status)
                  note_mismatch("status", int'(owed.status), int'(rsp_item.status));
            end
         end
         if (start && !busy) begin
            grant_or_refuse(req_item, predicted);
            expected_grants.push_back(predicted);
         end
         pending <= expected_grants.size();
      end
   end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the handle allocator: clock, reset, requests and verdict.
// Depends on fhra_pkg, fifo_recycling_handle_allocator_top and handle_pool_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import fhra_pkg::*;

   localparam int         NUM_HANDLES = 256;
   localparam int         CYCLE_LIMIT = 60000;
   // request code the block ignores
   localparam logic [1:0] REQ_UNUSED  = 2'd3;

   logic         clock    = 1'b0;
   logic         reset    = 1'b1;
   logic         start    = 1'b0;
   req_item_type req_item = '0;
   logic         busy;
   logic         rsp_strobe;
   rsp_item_type rsp_item;

   int mismatches, pending, n_checked, n_recycled, n_exhausted, n_refused;

   // Stimulus bookkeeping: handles believed to be out, and request kinds in flight
   logic [7:0] owned [$];
   logic [1:0] sent_kinds [$];
   logic [1:0] resp_kind;
   logic [7:0] last_freed = '0;
   bit         idling_on = 1'b1;
   int         n_sent = 0;
   int         exhausted_seen = 0;
   int         cycle_count = 0;

   fifo_recycling_handle_allocator_top #(
      .NUM_HANDLES(NUM_HANDLES)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   handle_pool_checker #(
      .NUM_HANDLES(NUM_HANDLES)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .mismatches (mismatches),
      .pending    (pending),
      .n_checked  (n_checked),
      .n_recycled (n_recycled),
      .n_exhausted(n_exhausted),
      .n_refused  (n_refused)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abandon a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Run stopped: no completion within %0d cycles", CYCLE_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Learn which handles were granted, so that frees can name them
   always @(posedge clock) begin
      if (!reset && rsp_strobe && sent_kinds.size() != 0) begin
         resp_kind = sent_kinds.pop_front();
         if (rsp_item.status == ST_EXHAUSTED)
            exhausted_seen++;
         if ((resp_kind == REQ_ALLOC || resp_kind == REQ_TRY) && rsp_item.status == ST_OK)
            owned.push_back(rsp_item.granted_handle);
      end
   end

   // Offer one item and hold it until the block takes it
   task automatic send_request(input logic [1:0] kind, input logic [7:0] handle);
      int idx [$];
      bit was_busy;
      if (idling_on && $urandom_range(0, 99) < 11) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      if (kind == REQ_FREE) begin
         idx = owned.find_first_index(x) with (x == handle);
         if (idx.size() != 0)
            owned.delete(idx[0]);
         last_freed = handle;
      end
      start    <= 1'b1;
      req_item <= '{req_type: kind, release_handle: handle};
      sent_kinds.push_back(kind);
      // busy is settled by the falling edge; low there means taken at the next rise
      do begin
         @(negedge clock);
         was_busy = busy;
         @(posedge clock);
      end while (was_busy);
      n_sent++;
   endtask

   // Draw one random item from the given mix; the remainder is tries and bad requests
   task automatic send_random(input int alloc_pct, input int free_pct);
      int         r;
      logic [7:0] junk;
      r    = $urandom_range(0, 99);
      junk = 8'($urandom);
      if (r < alloc_pct) begin
         send_request(REQ_ALLOC, junk);
      end else if (r < alloc_pct + free_pct && owned.size() != 0) begin
         send_request(REQ_FREE, owned[$urandom_range(0, owned.size() - 1)]);
      end else begin
         case ($urandom_range(0, 3))
            0:       send_request(REQ_TRY, junk);
            1:       send_request(REQ_FREE, last_freed);
            2:       send_request(REQ_FREE, junk);
            default: send_request(REQ_UNUSED, junk);
         endcase
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty pool, bad frees, reuse order, double free, ignored code
      send_request(REQ_TRY,    8'h00);
      send_request(REQ_FREE,   8'h00);
      send_request(REQ_FREE,   8'hFF);
      send_request(REQ_ALLOC,  8'hFF);
      send_request(REQ_ALLOC,  8'h00);
      send_request(REQ_ALLOC,  8'hAA);
      send_request(REQ_UNUSED, 8'hFF);
      send_request(REQ_FREE,   8'h01);
      send_request(REQ_FREE,   8'h01);
      send_request(REQ_FREE,   8'h00);
      send_request(REQ_TRY,    8'h55);
      send_request(REQ_ALLOC,  8'h00);
      send_request(REQ_ALLOC,  8'h00);
      send_request(REQ_TRY,    8'h00);
      send_request(REQ_FREE,   8'h02);
      send_request(REQ_FREE,   8'h03);
      send_request(REQ_FREE,   8'h00);
      send_request(REQ_FREE,   8'hAA);
      send_request(REQ_FREE,   8'h55);
      send_request(REQ_ALLOC,  8'hFF);
      send_request(REQ_TRY,    8'hFF);
      send_request(REQ_ALLOC,  8'h00);
      send_request(REQ_UNUSED, 8'h00);

      // Mixed traffic, with a long stretch of back-to-back items
      for (int i = 0; i < 80; i++) begin
         idling_on = !(i >= 15 && i < 70);
         send_random(45, 35);
      end
      idling_on = 1'b1;

      // Allocation-heavy until the pool has run dry a few times
      for (int i = 0; i < 400 && exhausted_seen < 6; i++)
         send_random(90, 4);

      // Drain back: deep free queue, tries and reuse after exhaustion
      for (int i = 0; i < 40; i++)
         send_random(25, 60);

      start <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (8) @(posedge clock);

      $display("Summary: %0d requests driven, %0d responses checked, %0d from recycled handles",
               n_sent, n_checked, n_recycled);
      $display("Summary: %0d pool-exhausted answers, %0d refused tries or frees",
               n_exhausted, n_refused);
      if (mismatches == 0 && pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
